@@ hw/rtl/wsd_pkg.sv @@
// shared types and constants for the websocket frame deframer
// no dependencies; imported by wsd_parser and websocket_frame_deframer_top
package wsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 64;
    localparam int KEY_W    = 32;

    // 7-bit length codes that announce an extended length field
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // extended length byte counts (bytes still to come minus one) and last key byte index
    localparam logic [2:0] EXT16_CNT = 3'd1;
    localparam logic [2:0] EXT64_CNT = 3'd7;
    localparam logic [2:0] KEY_LAST  = 3'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                data_present;
        logic                frame_end;
    } t_result;

endpackage

@@ hw/rtl/websocket_frame_deframer_top.sv @@
// websocket frame deframer, client-to-server framing
// one byte beat in on i_valid/o_stall, one result beat out on o_valid/i_stall.
// header bytes (opcode, length, extended length, mask key) give no result;
// each payload byte gives one result, unmasked with the rolling key if the mask
// bit is set, and tagged with the frame opcode and a frame_end flag on its last byte.
// a zero-length frame gives one result with data_present low, frame_end high.
// an accepted beat passes through the input register, then the result register,
// before its result shows on the ports.
// throughput: one byte per cycle while the receiver does not stall, set by the
// combinational parse step between the input register and the result register.
// reset (synchronous, active low) returns the parser to the first header byte
// and empties both registers.
// when the receiver stalls a valid result, the result register holds; an empty
// input register still takes one more beat, then o_stall rises until the result is taken.
// depends on wsd_pkg and wsd_parser
module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [BYTE_W-1:0]   i_in_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic [OPCODE_W-1:0] o_frame_opcode,
    output logic                o_data_present,
    output logic                o_frame_end
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic    out_free;
    logic    proc;
    logic    res_valid;
    t_result res;

    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= proc && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
        end
        if (proc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_frame_opcode = r_out.frame_opcode;
    assign o_data_present = r_out.data_present;
    assign o_frame_end    = r_out.frame_end;

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data_present |-> o_frame_end && o_out_byte == '0)
        else $error("empty frame marker malformed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_out))
        else $error("stalled result beat changed");

endmodule

@@ hw/rtl/wsd_parser.sv @@
// frame header parser and payload unmasking, one byte per enabled cycle
// depends on wsd_pkg for widths, length codes and the result struct
module wsd_parser
    import wsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    logic [2:0]          r_phase,  n_phase;
    logic [OPCODE_W-1:0] r_opcode, n_opcode;
    logic                r_mask,   n_mask;
    logic [2:0]          r_cnt,    n_cnt;
    logic [LEN_W-1:0]    r_rem,    n_rem;
    logic [KEY_W-1:0]    r_key,    n_key;
    logic [1:0]          r_kidx,   n_kidx;

    logic [BYTE_W-1:0] key_byte;
    logic              len_done;   // length field complete this byte
    logic              hdr_done;   // whole header complete this byte

    always_comb begin
        unique case (r_kidx)
            2'd0: key_byte = r_key[31:24];
            2'd1: key_byte = r_key[23:16];
            2'd2: key_byte = r_key[15:8];
            2'd3: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_mask      = r_mask;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_key       = r_key;
        n_kidx      = r_kidx;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{out_byte: '0, frame_opcode: r_opcode, data_present: 1'b0,
                        frame_end: 1'b1};

        unique case (r_phase)
            PH_HDR1: begin
                n_mask = i_byte[7];
                n_rem  = '0;
                if (i_byte[6:0] == LEN_CODE_16) begin
                    n_cnt   = EXT16_CNT;
                    n_phase = PH_EXT;
                end else if (i_byte[6:0] == LEN_CODE_64) begin
                    n_cnt   = EXT64_CNT;
                    n_phase = PH_EXT;
                end else begin
                    n_rem    = {{(LEN_W-7){1'b0}}, i_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_rem = {r_rem[LEN_W-BYTE_W-1:0], i_byte};
                if (r_cnt == 3'd0) begin
                    len_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[KEY_W-BYTE_W-1:0], i_byte};
                if (r_cnt >= KEY_LAST) begin
                    hdr_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_DATA: begin
                o_res_valid        = 1'b1;
                o_res.out_byte     = r_mask ? (i_byte ^ key_byte) : i_byte;
                o_res.data_present = 1'b1;
                n_kidx             = r_kidx + 2'd1;
                if (r_rem != '0) begin
                    n_rem = r_rem - LEN_W'(1);
                end
                // last payload byte when the count drops to zero
                o_res.frame_end = (r_rem <= LEN_W'(1));
                if (r_rem <= LEN_W'(1)) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                // first header byte, unused codes land here too
                n_opcode = i_byte[OPCODE_W-1:0];
                n_phase  = PH_HDR1;
            end
        endcase

        if (len_done) begin
            if (n_mask) begin
                n_key   = '0;
                n_cnt   = '0;
                n_phase = PH_KEY;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            n_kidx = '0;
            if (n_rem == '0) begin
                // empty frame gives a single marker result
                o_res_valid = 1'b1;
                n_phase     = PH_HDR0;
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_cnt    <= '0;
            r_rem    <= '0;
            r_key    <= '0;
            r_kidx   <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_cnt    <= n_cnt;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
        end
    end

    a_rst_phase: assert property (@(posedge i_clk)
        !i_rst_n |=> r_phase == PH_HDR0)
        else $error("parser phase not cleared by reset");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_rem != '0)
        else $error("payload phase with zero remaining length");

    a_key_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY |-> r_cnt <= KEY_LAST)
        else $error("key byte count out of range");

endmodule
